>>> hdl/sha1_pkg.sv
`timescale 1ns / 1ps
package sha1_pkg;

  localparam logic [31:0] K_ROUND0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  // One entry of the queue between front and back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } sha1_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> hdl/sha1_front.sv
`timescale 1ns / 1ps
module sha1_front
  import sha1_pkg::*;
#(
  parameter int unsigned DEPTH_LOG2 = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_last_byte,
  input  logic       in_push,
  output logic       in_full,
  output sha1_item_t q_item,
  output logic       q_valid,
  input  logic       q_take
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

  sha1_item_t                mem_r [DEPTH];
  logic [DEPTH_LOG2:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic                      push_ok, take_ok;

  assign in_full = (wp_r[DEPTH_LOG2] != rp_r[DEPTH_LOG2]) &&
                   (wp_r[DEPTH_LOG2-1:0] == rp_r[DEPTH_LOG2-1:0]);
  assign q_valid = (wp_r != rp_r);
  // Items that neither carry a byte nor end the message change nothing: dropped here.
  assign push_ok = in_push && !in_full && (in_byte_present || in_last_byte);
  assign take_ok = q_take && q_valid;
  assign wp_nxt  = wp_r + (DEPTH_LOG2 + 1)'(push_ok);
  assign rp_nxt  = rp_r + (DEPTH_LOG2 + 1)'(take_ok);
  assign q_item  = mem_r[rp_r[DEPTH_LOG2-1:0]];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r[DEPTH_LOG2-1:0]] <= '{in_data_byte, in_byte_present, in_last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !push_ok) else $error("queue write while full");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take_ok |-> q_valid) else $error("queue read while empty");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) <= (DEPTH_LOG2 + 1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

>>> hdl/sha1_back.sv
`timescale 1ns / 1ps
module sha1_back
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha1_item_t  q_item,
  input  logic        q_valid,
  output logic        q_take,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_empty,
  input  logic        out_pop
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_COMP  = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t       st_r, st_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [63:0]  bits_r, len_r;
  logic [6:0]   rnd_r;
  logic [5:0]   pos_r;
  logic [2:0]   oidx_r;
  logic         fin_r;        // message ends after the pending compression
  logic         after_len_r;  // compression follows length bytes
  logic         mark_r;       // the 0x80 marker is still owed to the padding

  logic [5:0]   bpos;
  logic [31:0]  wsel, wexp, f, k, t;
  logic [3:0]   ri;
  logic [7:0]   wr_byte;
  logic         wr_en;
  logic [5:0]   wr_pos;

  assign bpos = bits_r[8:3];
  assign ri   = rnd_r[3:0];
  assign wexp = rotl(w_r[4'(ri + 4'd13)] ^ w_r[4'(ri + 4'd8)] ^ w_r[4'(ri + 4'd2)] ^
                     w_r[ri], 1);
  assign wsel = (rnd_r < 7'd16) ? w_r[ri] : wexp;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K_ROUND0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K_ROUND1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K_ROUND2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_ROUND3;
    end
  end
  assign t = rotl(a_r, 5) + f + e_r + k + wsel;

  assign q_take = (st_r == ST_IDLE) && q_valid;

  // Byte writes into the block buffer, from message, padding or length.
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = 8'h00;
    wr_pos  = pos_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_take) begin
          wr_en   = q_item.byte_present || q_item.last_byte;
          wr_byte = q_item.byte_present ? q_item.data_byte : PAD_BYTE;
          wr_pos  = bpos;
        end
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = mark_r ? PAD_BYTE : 8'h00;
      end
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = len_r[63 - 8 * int'(pos_r[2:0]) -: 8];
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_take) begin
          if (wr_pos == 6'd63) st_nxt = ST_COMP;
          else if (q_item.byte_present && !q_item.last_byte) st_nxt = ST_IDLE;
          else if (q_item.byte_present) st_nxt = ST_PAD;
          else st_nxt = (wr_pos + 6'd1 == LEN_POS) ? ST_LEN : ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos_r == 6'd63) st_nxt = ST_COMP;
        else if (pos_r + 6'd1 == LEN_POS) st_nxt = ST_LEN;
      end
      ST_LEN: begin
        if (pos_r == 6'd63) st_nxt = ST_COMP;
      end
      ST_COMP: begin
        if (rnd_r == LAST_ROUND) st_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (!fin_r) st_nxt = ST_IDLE;
        else if (after_len_r) st_nxt = ST_OUT;
        else st_nxt = ST_PAD;
      end
      ST_OUT: begin
        if (out_pop && oidx_r == 3'd4) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_r[wr_pos[5:2]][8 * (3 - int'(wr_pos[1:0])) +: 8] <= wr_byte;
    end
    if (st_r == ST_COMP && rnd_r >= 7'd16) begin
      w_r[ri] <= wexp;
    end
    if (st_r == ST_FOLD) begin
      for (int i = 0; i < 16; i++) w_r[i] <= '0;
    end
    if (st_r == ST_COMP) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= rotl(b_r, 30);
      d_r <= c_r;
      e_r <= d_r;
    end else begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      h_r         <= '{H_INIT0, H_INIT1, H_INIT2, H_INIT3, H_INIT4};
      bits_r      <= '0;
      len_r       <= '0;
      rnd_r       <= '0;
      pos_r       <= '0;
      oidx_r      <= '0;
      fin_r       <= 1'b0;
      after_len_r <= 1'b0;
      mark_r      <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (q_take) begin
            if (q_item.byte_present) bits_r <= bits_r + 64'd8;
            fin_r       <= q_item.last_byte;
            after_len_r <= 1'b0;
            len_r       <= q_item.byte_present ? bits_r + 64'd8 : bits_r;
            // Without a byte the 0x80 marker is written this cycle.
            pos_r       <= bpos + 6'd1;
            mark_r      <= q_item.byte_present && q_item.last_byte;
            rnd_r       <= '0;
          end
        end
        ST_PAD: begin
          pos_r  <= pos_r + 6'd1;
          mark_r <= 1'b0;
          rnd_r  <= '0;
        end
        ST_LEN: begin
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd63) after_len_r <= 1'b1;
          rnd_r <= '0;
        end
        ST_COMP: rnd_r <= rnd_r + 7'd1;
        ST_FOLD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          rnd_r  <= '0;
          oidx_r <= '0;
        end
        ST_OUT: begin
          if (out_pop) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd4) begin
              h_r    <= '{H_INIT0, H_INIT1, H_INIT2, H_INIT3, H_INIT4};
              bits_r <= '0;
              fin_r  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_empty       = (st_r != ST_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd4);

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COMP) |-> (rnd_r <= LAST_ROUND)) else $error("round out of range");
  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |-> (oidx_r <= 3'd4)) else $error("digest index out of range");
  a_comp_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COMP && rnd_r == LAST_ROUND) |=> (st_r == ST_FOLD))
    else $error("compression did not finish");
  a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |-> fin_r) else $error("digest without end of message");
`endif

endmodule

>>> hdl/sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps
// The back end takes a byte item while idle; the 64th byte of a block starts a compression
// (80 rounds on one round unit plus the chaining fold). A last item adds byte-serial
// padding, one or two compressions, then five digest words, one per pop. A 4-entry
// queue parts input from the back end.
// rst_n is synchronous and active low; after it the hasher holds the initial values.
module sha1_byte_stream_hasher
  import sha1_pkg::*;
#(
  parameter int unsigned QUEUE_LOG2 = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  input  logic        push,
  output logic        full,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        empty,
  input  logic        pop
);

  sha1_item_t q_item;
  logic       q_valid, q_take;

  sha1_front #(.DEPTH_LOG2(QUEUE_LOG2)) u_front (
    .clk, .rst_n, .in_data_byte, .in_byte_present, .in_last_byte,
    .in_push(push), .in_full(full), .q_item, .q_valid, .q_take
  );

  sha1_back u_back (
    .clk, .rst_n, .q_item, .q_valid, .q_take,
    .out_digest_word, .out_word_index, .out_last_word,
    .out_empty(empty), .out_pop(pop)
  );

endmodule
